/* sv/minimap_radial_clamp_defines.svh */
// Assertion macros shared by the minimap clamp RTL.
// Both macros use the enclosing module's clk; the first also uses its rst.
`ifndef MINIMAP_RADIAL_CLAMP_DEFINES_SVH
`define MINIMAP_RADIAL_CLAMP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define MRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define MRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRC_ASSERT(lbl, prop, msg)
`define MRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/mrc_pkg.sv */
package mrc_pkg;

  // Widths of the internal datapath.
  localparam int MAG_W   = 28;  // scaled offset magnitude, Q.4
  localparam int SUM_W   = 57;  // sum of squares
  localparam int ROOT_W  = 29;  // length, Q.4
  localparam int TRIAL_W = 59;  // square root trial value
  localparam int PROD_W  = 44;  // magnitude times radius
  localparam int DIV_W   = 45;  // divider remainder
  localparam int QUO_W   = 16;  // pulled-in magnitude

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MAP_SCALE    = 2'd0,
    CFG_CENTER_X     = 2'd1,
    CFG_CENTER_Y     = 2'd2,
    CFG_CLAMP_RADIUS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [23:0] object_x;
    logic signed [23:0] object_z;
    logic signed [23:0] viewer_x;
    logic signed [23:0] viewer_z;
    logic               is_active;
    logic               is_enemy;
  } in_word_t;

  typedef struct packed {
    logic [15:0] icon_x;
    logic [15:0] icon_y;
    logic        icon_is_enemy;
  } out_word_t;

  // Per-item data that rides along the cell chains.
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic             enemy;
  } carry_t;

endpackage

/* sv/mrc_sqrt_cell.sv */
// One result bit of the integer square root, registered.
module mrc_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       src_valid,
  input  logic [mrc_pkg::SUM_W-1:0]  src_rem,
  input  logic [mrc_pkg::ROOT_W-1:0] src_root,
  input  mrc_pkg::carry_t            src_carry,
  output logic                       valid,
  output logic [mrc_pkg::SUM_W-1:0]  rem,
  output logic [mrc_pkg::ROOT_W-1:0] root,
  output mrc_pkg::carry_t            carry
);

  logic [mrc_pkg::TRIAL_W-1:0] trial;
  logic [mrc_pkg::TRIAL_W-1:0] rem_wide;
  logic                        fits;
  logic [mrc_pkg::SUM_W-1:0]   rem_next;
  logic [mrc_pkg::ROOT_W-1:0]  root_next;

  // Growth of the square when this bit is set: 2*root*2^BIT + 4^BIT.
  always_comb begin
    trial = (mrc_pkg::TRIAL_W'(src_root) << (BIT + 1))
          | (mrc_pkg::TRIAL_W'(1) << (2 * BIT));
    rem_wide = mrc_pkg::TRIAL_W'(src_rem);
    fits = rem_wide >= trial;
    rem_next = fits ? mrc_pkg::SUM_W'(rem_wide - trial) : src_rem;
    root_next = fits ? (src_root | (mrc_pkg::ROOT_W'(1) << BIT)) : src_root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem   <= rem_next;
      root  <= root_next;
      carry <= src_carry;
    end
  end

endmodule

/* sv/mrc_div_cell.sv */
// One quotient bit of both pull-in divisions, registered.
module mrc_div_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       src_valid,
  input  logic [mrc_pkg::DIV_W-1:0]  src_rem_x,
  input  logic [mrc_pkg::DIV_W-1:0]  src_rem_y,
  input  logic [mrc_pkg::QUO_W-1:0]  src_quo_x,
  input  logic [mrc_pkg::QUO_W-1:0]  src_quo_y,
  input  logic [mrc_pkg::ROOT_W-1:0] src_len,
  input  logic                       src_clamp,
  input  mrc_pkg::carry_t            src_carry,
  output logic                       valid,
  output logic [mrc_pkg::DIV_W-1:0]  rem_x,
  output logic [mrc_pkg::DIV_W-1:0]  rem_y,
  output logic [mrc_pkg::QUO_W-1:0]  quo_x,
  output logic [mrc_pkg::QUO_W-1:0]  quo_y,
  output logic [mrc_pkg::ROOT_W-1:0] len,
  output logic                       clamp,
  output mrc_pkg::carry_t            carry
);

  logic [mrc_pkg::DIV_W-1:0] shifted;
  logic                      fits_x;
  logic                      fits_y;

  // Restoring step: subtract len * 2^BIT where it fits.
  always_comb begin
    shifted = mrc_pkg::DIV_W'(src_len) << BIT;
    fits_x  = src_rem_x >= shifted;
    fits_y  = src_rem_y >= shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x <= fits_x ? src_rem_x - shifted : src_rem_x;
      rem_y <= fits_y ? src_rem_y - shifted : src_rem_y;
      quo_x <= src_quo_x | (fits_x ? mrc_pkg::QUO_W'(1) << BIT : '0);
      quo_y <= src_quo_y | (fits_y ? mrc_pkg::QUO_W'(1) << BIT : '0);
      len   <= src_len;
      clamp <= src_clamp;
      carry <= src_carry;
    end
  end

endmodule

/* sv/minimap_radial_clamp.sv */
// Channel  Direction  Word / fields
// in       input      in_data: object and viewer x/z, is_active, is_enemy
// out      output     out_data: icon_x, icon_y, icon_is_enemy
// cfg      input      cfg_index, cfg_data (always ready)
//
// One word is accepted per cycle while the output is not stalled.
// The pipeline holds the 29 square-root cells and the 16 divider cells.
// Reset clears all valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; inactive words leave no result.
`include "minimap_radial_clamp_defines.svh"
module minimap_radial_clamp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrc_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrc_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  mrc_pkg::cfg_index_t cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int RW = mrc_pkg::ROOT_W;
  localparam int QW = mrc_pkg::QUO_W;

  logic        en;
  logic [15:0] map_scale;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] clamp_radius;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_scale    <= 16'd256;
      center_x     <= 16'd1600;
      center_y     <= 16'd1600;
      clamp_radius <= 16'd1600;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mrc_pkg::CFG_MAP_SCALE:    map_scale    <= cfg_data;
        mrc_pkg::CFG_CENTER_X:     center_x     <= cfg_data;
        mrc_pkg::CFG_CENTER_Y:     center_y     <= cfg_data;
        mrc_pkg::CFG_CLAMP_RADIUS: clamp_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage a: input register; inactive words enter as bubbles.
  logic              v_a;
  mrc_pkg::in_word_t word_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= in_valid && in_data.is_active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_a <= in_data;
    end
  end

  // Stage b: offsets and their magnitudes.
  logic signed [24:0] rel_x;
  logic signed [24:0] rel_z;
  logic               v_b;
  logic [24:0]        mag_bx;
  logic [24:0]        mag_bz;
  logic               neg_bx;
  logic               neg_bz;
  logic               pos_bz;
  logic               enemy_b;

  always_comb begin
    rel_x = 25'(word_a.object_x) - 25'(word_a.viewer_x);
    rel_z = 25'(word_a.object_z) - 25'(word_a.viewer_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_bx  <= rel_x[24] ? 25'(-rel_x) : 25'(rel_x);
      mag_bz  <= rel_z[24] ? 25'(-rel_z) : 25'(rel_z);
      neg_bx  <= rel_x[24];
      neg_bz  <= rel_z[24];
      pos_bz  <= !rel_z[24] && (rel_z != 25'sd0);
      enemy_b <= word_a.is_enemy;
    end
  end

  // Stage c: scale to Q.4; screen y is minus world z.
  logic [40:0]     scl_x;
  logic [40:0]     scl_z;
  logic            v_c;
  mrc_pkg::carry_t carry_c;

  always_comb begin
    scl_x = 41'(mag_bx) * 41'(map_scale);
    scl_z = 41'(mag_bz) * 41'(map_scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_c.mag_x <= scl_x[39:12];
      carry_c.mag_y <= scl_z[39:12];
      carry_c.neg_x <= neg_bx;
      carry_c.neg_y <= pos_bz && !neg_bz;
      carry_c.enemy <= enemy_b;
    end
  end

  // Stage d: squares.
  logic                          v_d;
  logic [2*mrc_pkg::MAG_W-1:0]   sq_x;
  logic [2*mrc_pkg::MAG_W-1:0]   sq_y;
  mrc_pkg::carry_t               carry_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else if (en) begin
      v_d <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x    <= (2*mrc_pkg::MAG_W)'(carry_c.mag_x) * (2*mrc_pkg::MAG_W)'(carry_c.mag_x);
      sq_y    <= (2*mrc_pkg::MAG_W)'(carry_c.mag_y) * (2*mrc_pkg::MAG_W)'(carry_c.mag_y);
      carry_d <= carry_c;
    end
  end

  // Stage e: sum of squares feeds the root chain.
  logic                      sv [0:RW];
  logic [mrc_pkg::SUM_W-1:0] srem [0:RW];
  logic [RW-1:0]             sroot [0:RW];
  mrc_pkg::carry_t           scarry [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srem[0]   <= mrc_pkg::SUM_W'(sq_x) + mrc_pkg::SUM_W'(sq_y);
      sroot[0]  <= '0;
      scarry[0] <= carry_d;
    end
  end

  // Square root: one cell per result bit, most significant first.
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    mrc_sqrt_cell #(.BIT(RW - 1 - i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (sv[i]),
      .src_rem   (srem[i]),
      .src_root  (sroot[i]),
      .src_carry (scarry[i]),
      .valid     (sv[i+1]),
      .rem       (srem[i+1]),
      .root      (sroot[i+1]),
      .carry     (scarry[i+1])
    );
  end

  // Stage f: clamp decision and dividends.
  logic                      dv [0:QW];
  logic [mrc_pkg::DIV_W-1:0] drem_x [0:QW];
  logic [mrc_pkg::DIV_W-1:0] drem_y [0:QW];
  logic [QW-1:0]             dquo_x [0:QW];
  logic [QW-1:0]             dquo_y [0:QW];
  logic [RW-1:0]             dlen [0:QW];
  logic                      dclamp [0:QW];
  mrc_pkg::carry_t           dcarry [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_x[0] <= mrc_pkg::DIV_W'(mrc_pkg::PROD_W'(scarry[RW].mag_x)
                   * mrc_pkg::PROD_W'(clamp_radius));
      drem_y[0] <= mrc_pkg::DIV_W'(mrc_pkg::PROD_W'(scarry[RW].mag_y)
                   * mrc_pkg::PROD_W'(clamp_radius));
      dquo_x[0] <= '0;
      dquo_y[0] <= '0;
      dlen[0]   <= sroot[RW];
      dclamp[0] <= sroot[RW] > RW'(clamp_radius);
      dcarry[0] <= scarry[RW];
    end
  end

  // Divider: one cell per quotient bit, both axes side by side.
  for (genvar j = 0; j < QW; j++) begin : g_div
    mrc_div_cell #(.BIT(QW - 1 - j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .src_valid (dv[j]),
      .src_rem_x (drem_x[j]),
      .src_rem_y (drem_y[j]),
      .src_quo_x (dquo_x[j]),
      .src_quo_y (dquo_y[j]),
      .src_len   (dlen[j]),
      .src_clamp (dclamp[j]),
      .src_carry (dcarry[j]),
      .valid     (dv[j+1]),
      .rem_x     (drem_x[j+1]),
      .rem_y     (drem_y[j+1]),
      .quo_x     (dquo_x[j+1]),
      .quo_y     (dquo_y[j+1]),
      .len       (dlen[j+1]),
      .clamp     (dclamp[j+1]),
      .carry     (dcarry[j+1])
    );
  end

  // Output stage: center plus signed offset, saturated.
  logic [mrc_pkg::MAG_W-1:0] fin_x;
  logic [mrc_pkg::MAG_W-1:0] fin_y;
  logic [29:0]               pos_x;
  logic [29:0]               pos_y;
  logic [15:0]               sat_x;
  logic [15:0]               sat_y;

  always_comb begin
    fin_x = dclamp[QW] ? mrc_pkg::MAG_W'(dquo_x[QW]) : dcarry[QW].mag_x;
    fin_y = dclamp[QW] ? mrc_pkg::MAG_W'(dquo_y[QW]) : dcarry[QW].mag_y;
    pos_x = dcarry[QW].neg_x ? 30'(center_x) - 30'(fin_x) : 30'(center_x) + 30'(fin_x);
    pos_y = dcarry[QW].neg_y ? 30'(center_y) - 30'(fin_y) : 30'(center_y) + 30'(fin_y);
    if (pos_x[29]) begin
      sat_x = 16'd0;
    end else if (|pos_x[28:16]) begin
      sat_x = 16'hFFFF;
    end else begin
      sat_x = pos_x[15:0];
    end
    if (pos_y[29]) begin
      sat_y = 16'd0;
    end else if (|pos_y[28:16]) begin
      sat_y = 16'hFFFF;
    end else begin
      sat_y = pos_y[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.icon_x        <= sat_x;
      out_data.icon_y        <= sat_y;
      out_data.icon_is_enemy <= dcarry[QW].enemy;
    end
  end

  // Checks on the pipeline.
  `MRC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `MRC_ASSERT(a_inactive_drop, in_valid && in_ready && !in_data.is_active |=> !v_a, "inactive word entered pipeline")
  `MRC_ASSERT(a_quo_in_radius, dv[QW] && dclamp[QW] |-> (dquo_x[QW] <= clamp_radius) && (dquo_y[QW] <= clamp_radius), "pulled-in offset beyond radius")
  `MRC_ASSERT(a_noclamp_short, dv[QW] && !dclamp[QW] |-> dlen[QW] <= RW'(clamp_radius), "unclamped length beyond radius")

endmodule
